// File: rtl/skyrp_pkg.sv
// shared types and constants for the skyline rectangle packer
package skyrp_pkg;

  typedef struct packed {
    logic [14:0] tile_width;
    logic [14:0] tile_height;
    logic        new_pack;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] pos_x;
    logic [13:0] pos_y;
  } out_t;

  typedef struct packed {
    logic [14:0] x;
    logic [15:0] y;
    logic [14:0] w;
  } seg_t;

  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_WIDE   = 2'd1;
  localparam logic [1:0] ST_NOROOM = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_GUTTER       = 2'd2;

  localparam logic [14:0] RESET_ATLAS_WIDTH  = 15'd1024;
  localparam logic [14:0] RESET_ATLAS_HEIGHT = 15'd1024;
  localparam logic [7:0]  RESET_GUTTER       = 8'd0;

endpackage

// File: rtl/skyrp_mem.sv
// segment store: two banks, one write port, one registered read port
module skyrp_mem import skyrp_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  seg_t          wdata,
  input  logic [AW-1:0] raddr,
  output seg_t          rdata
);

  seg_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/skyrp_core.sv
// placement sequencer: skyline flatten, bottom-left search and rebuild
module skyrp_core import skyrp_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int IW = 6,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  in_t           item,
  input  logic [14:0]   atlas_width,
  input  logic [14:0]   atlas_height,
  input  logic [7:0]    gutter,
  output logic          busy,
  output logic          res_valid,
  output out_t          res,
  input  logic          res_take,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output seg_t          mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  seg_t          mem_rdata
);

  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FLAT  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SUSE  = 4'd4;
  localparam logic [3:0] S_RRD   = 4'd5;
  localparam logic [3:0] S_RUSE  = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_FINAL = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]         state;
  logic               bank;
  logic [CW-1:0]      count;
  logic               flat_init;
  logic [14:0]        w;
  logic [14:0]        h;
  logic               np;
  logic [CW-1:0]      i;
  logic [CW-1:0]      j;
  logic [15:0]        ycur;
  logic signed [16:0] rem;
  logic [14:0]        sx;
  logic               found;
  logic [14:0]        best_x;
  logic [15:0]        best_y;
  logic [1:0]         status;
  logic [14:0]        cx0;
  logic [15:0]        cx1;
  logic [14:0]        rsv;
  logic [15:0]        hgt;
  logic               placed;
  logic [CW-1:0]      ncount;
  logic               nfull;
  seg_t               pend;
  logic [CW-1:0]      k;
  seg_t               slot [3];
  logic [1:0]         ecnt;
  logic [1:0]         eidx;

  // search datapath
  logic [15:0]        xend;
  logic               skip;
  logic [15:0]        ynew;
  logic signed [16:0] remnew;
  logic [14:0]        xs;
  logic [16:0]        ytop;
  logic               better;
  logic [CW-1:0]      jn;
  logic [CW-1:0]      in1;
  logic [CW-1:0]      kn;
  logic [15:0]        wg;
  logic [14:0]        room;
  logic [14:0]        rsv_c;

  // rebuild datapath
  logic [15:0]        seg_b;
  seg_t               slot_n [3];
  logic [1:0]         ecnt_n;
  logic               placed_n;
  seg_t               e;
  logic               merge;
  logic [CW-1:0]      ncm1;
  logic               emit_last;

  assign xend   = {1'b0, mem_rdata.x} + {1'b0, w};
  assign skip   = (j == i) && (xend > {1'b0, atlas_width});
  assign ynew   = (rem > 17'sd0 && mem_rdata.y > ycur) ? mem_rdata.y : ycur;
  assign remnew = (rem > 17'sd0) ? rem - $signed({2'b00, mem_rdata.w}) : rem;
  assign xs     = (j == i) ? mem_rdata.x : sx;
  assign ytop   = {1'b0, ynew} + {2'b00, h};
  assign better = (ytop <= {2'b00, atlas_height}) &&
                  (!found || ynew < best_y || (ynew == best_y && xs < best_x));
  assign jn     = j + 1'b1;
  assign in1    = i + 1'b1;
  assign kn     = k + 1'b1;
  assign wg     = {1'b0, w} + {8'd0, gutter};
  assign room   = atlas_width - best_x;
  assign rsv_c  = (wg > {1'b0, room}) ? room : wg[14:0];

  assign seg_b = {1'b0, mem_rdata.x} + {1'b0, mem_rdata.w};

  always_comb begin
    slot_n[0] = '0;
    slot_n[1] = '0;
    slot_n[2] = '0;
    ecnt_n    = 2'd0;
    placed_n  = placed;
    if (seg_b <= {1'b0, cx0}) begin
      slot_n[0] = mem_rdata;
      ecnt_n    = 2'd1;
    end else if ({1'b0, mem_rdata.x} >= cx1) begin
      if (!placed) begin
        slot_n[0] = '{x: cx0, y: hgt, w: rsv};
        slot_n[1] = mem_rdata;
        ecnt_n    = 2'd2;
        placed_n  = 1'b1;
      end else begin
        slot_n[0] = mem_rdata;
        ecnt_n    = 2'd1;
      end
    end else begin
      if (mem_rdata.x < cx0) begin
        slot_n[ecnt_n] = '{x: mem_rdata.x, y: mem_rdata.y, w: cx0 - mem_rdata.x};
        ecnt_n         = ecnt_n + 2'd1;
      end
      if (!placed) begin
        slot_n[ecnt_n] = '{x: cx0, y: hgt, w: rsv};
        ecnt_n         = ecnt_n + 2'd1;
        placed_n       = 1'b1;
      end
      if (seg_b > cx1) begin
        slot_n[ecnt_n] = '{x: cx1[14:0], y: mem_rdata.y, w: 15'(seg_b - cx1)};
        ecnt_n         = ecnt_n + 2'd1;
      end
    end
  end

  assign e     = slot[eidx];
  assign merge = (ncount != '0) && (pend.y == e.y) &&
                 (({1'b0, pend.x} + {1'b0, pend.w}) == {1'b0, e.x});
  assign ncm1  = ncount - 1'b1;
  assign emit_last = (eidx + 2'd1 >= ecnt);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {bank, ncm1[IW-1:0]};
    mem_wdata = pend;
    mem_raddr = {bank, j[IW-1:0]};
    unique case (state)
      S_FLAT: begin
        mem_we    = 1'b1;
        mem_waddr = {bank, {IW{1'b0}}};
        mem_wdata = '{x: 15'd0, y: 16'd0, w: np ? atlas_width : RESET_ATLAS_WIDTH};
      end
      S_RRD: begin
        mem_raddr = {bank, k[IW-1:0]};
      end
      S_EMIT: begin
        mem_we    = !merge && (ncount < MAXC) && (ncount != '0);
        mem_waddr = {~bank, ncm1[IW-1:0]};
      end
      S_FINAL: begin
        mem_we    = placed && !nfull;
        mem_waddr = {~bank, ncm1[IW-1:0]};
      end
      default: begin
      end
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{status: status,
                       pos_x: (status == ST_PLACED) ? best_x[13:0] : 14'd0,
                       pos_y: (status == ST_PLACED) ? best_y[13:0] : 14'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bank      <= 1'b0;
      count     <= CW'(1);
      flat_init <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            w     <= item.tile_width;
            h     <= item.tile_height;
            np    <= item.new_pack;
            state <= (item.new_pack || flat_init) ? S_FLAT : S_CHK;
          end
        end
        S_FLAT: begin
          count     <= CW'(1);
          flat_init <= 1'b0;
          state     <= S_CHK;
        end
        S_CHK: begin
          i     <= '0;
          j     <= '0;
          ycur  <= '0;
          rem   <= $signed({2'b00, w});
          found <= 1'b0;
          if (w > atlas_width) begin
            status <= ST_WIDE;
            state  <= S_DONE;
          end else begin
            state <= S_SRD;
          end
        end
        S_SRD: begin
          state <= S_SUSE;
        end
        S_SUSE: begin
          if (j == i) begin
            sx <= mem_rdata.x;
          end
          ycur <= ynew;
          rem  <= remnew;
          if (!skip && remnew <= 17'sd0 && better) begin
            found  <= 1'b1;
            best_x <= xs;
            best_y <= ynew;
          end
          if (!skip && remnew > 17'sd0 && jn < count) begin
            j     <= jn;
            state <= S_SRD;
          end else if (in1 < count) begin
            i     <= in1;
            j     <= in1;
            ycur  <= '0;
            rem   <= $signed({2'b00, w});
            state <= S_SRD;
          end else begin
            state <= S_FINAL;
            // reuse final state entry by setting up rebuild below
            if (!found && !(!skip && remnew <= 17'sd0 && better)) begin
              status <= ST_NOROOM;
              state  <= S_DONE;
            end else begin
              state <= S_RRD;
            end
            k      <= '0;
            ncount <= '0;
            nfull  <= 1'b0;
            placed <= 1'b0;
          end
        end
        S_RRD: begin
          // geometry of the raised span, held for the whole rebuild
          if (k == '0) begin
            cx0 <= best_x;
            cx1 <= {1'b0, best_x} + {1'b0, rsv_c};
            rsv <= rsv_c;
            hgt <= best_y + {1'b0, h} + {8'd0, gutter};
            if (rsv_c == '0) begin
              status <= ST_PLACED;
              state  <= S_DONE;
            end else begin
              state <= S_RUSE;
            end
          end else begin
            state <= S_RUSE;
          end
        end
        S_RUSE: begin
          slot[0] <= slot_n[0];
          slot[1] <= slot_n[1];
          slot[2] <= slot_n[2];
          ecnt    <= ecnt_n;
          eidx    <= 2'd0;
          placed  <= placed_n;
          if (ecnt_n != 2'd0) begin
            state <= S_EMIT;
          end else if (kn < count) begin
            k     <= kn;
            state <= S_RRD;
          end else begin
            state <= S_FINAL;
          end
        end
        S_EMIT: begin
          if (merge) begin
            pend.w <= pend.w + e.w;
          end else if (ncount >= MAXC) begin
            nfull <= 1'b1;
          end else begin
            pend   <= e;
            ncount <= ncount + 1'b1;
          end
          eidx <= eidx + 2'd1;
          if (emit_last) begin
            if (kn < count) begin
              k     <= kn;
              state <= S_RRD;
            end else begin
              state <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          if (!placed) begin
            slot[0] <= '{x: cx0, y: hgt, w: rsv};
            ecnt    <= 2'd1;
            eidx    <= 2'd0;
            placed  <= 1'b1;
            state   <= S_EMIT;
          end else if (nfull) begin
            status <= ST_FULL;
            state  <= S_DONE;
          end else begin
            bank   <= ~bank;
            count  <= ncount;
            status <= ST_PLACED;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/skyline_rect_packer_unit.sv
// top level of the skyline rectangle packer
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | in_data (tile_width, tile_height, new_pack)
//  out     | out_valid/out_ready  | out_data (status, pos_x, pos_y)
//
// one tile at a time, paced by the single read port of the segment store:
// flatten when requested, width check, search with a read and a use state for
// each segment read over every start and the segments it spans, rebuild with a
// read and a use state per old segment and an emit per piece, then close and hand off
// rst restores the registers; first tile lays a flat segment, 1024 or atlas_width wide
// a held result in the output register does not block the next tile
module skyline_rect_packer_unit import skyrp_pkg::*; #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int AW = IW + 1;

  logic [14:0]   atlas_width;
  logic [14:0]   atlas_height;
  logic [7:0]    gutter;
  logic          busy;
  logic          res_valid;
  out_t          res;
  logic          res_take;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  seg_t          mem_wdata;
  logic [AW-1:0] mem_raddr;
  seg_t          mem_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign res_take  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= RESET_ATLAS_WIDTH;
      atlas_height <= RESET_ATLAS_HEIGHT;
      gutter       <= RESET_GUTTER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ATLAS_WIDTH:  atlas_width  <= cfg_data;
        CFG_ATLAS_HEIGHT: atlas_height <= cfg_data;
        CFG_GUTTER:       gutter       <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data <= res;
    end
  end

  skyrp_core #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .IW(IW),
    .AW(AW)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .start(in_valid && in_ready),
    .item(in_data),
    .atlas_width(atlas_width),
    .atlas_height(atlas_height),
    .gutter(gutter),
    .busy(busy),
    .res_valid(res_valid),
    .res(res),
    .res_take(res_take),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  skyrp_mem #(
    .DEPTH(2 ** AW),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_PLACED |-> out_data.pos_x == 14'd0 &&
    out_data.pos_y == 14'd0)
    else $error("failed placement carries a nonzero position");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("next tile taken while a tile is in flight");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a tile in flight");
`endif

endmodule
